### rtl/pru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types and codes for the pixel replicate upscaler.
// ----------------------------------------------------------------------------
package pru_pkg;

  localparam int PIXEL_W = 24;
  localparam int SCALE_REG_W = 5;
  localparam int WIDTH_REG_W = 11;
  localparam int CFG_DATA_W = 11;

  localparam logic CMD_PUSH   = 1'b0;
  localparam logic CMD_REPLAY = 1'b1;

  localparam logic ST_PIXEL  = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  typedef enum logic [0:0] {
    REG_SCALE        = 1'b0,
    REG_SOURCE_WIDTH = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic       command;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } cmd_req_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [1:0] pad_bytes;
    logic       row_end;
    logic       last;
    logic       status;
  } pix_req_t;

  typedef struct packed {
    logic               reject;
    logic               use_mem;
    logic               row_end;
    logic [1:0]         pad;
    logic [PIXEL_W-1:0] pixel;
  } job_t;

endpackage

### rtl/pru_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_line_store
// Single-port synchronous line memory with a registered read port.
// ----------------------------------------------------------------------------
module pru_line_store
  import pru_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               we,
  input  logic               re,
  input  logic [AW-1:0]      addr,
  input  logic [PIXEL_W-1:0] wdata,
  output logic [PIXEL_W-1:0] rdata
);

  logic [PIXEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### rtl/pru_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_ctrl
// Configuration registers, row position and phase tracking; issues line
// store accesses and hands one job per accepted request to the emitter.
// ----------------------------------------------------------------------------
module pru_ctrl
  import pru_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 16,
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int CNT_W = $clog2(MAX_SCALE + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  cfg_index_t         cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  cmd_req_t           cmd,
  output logic               mem_we,
  output logic               mem_re,
  output logic [COL_W-1:0]   mem_addr,
  output logic [PIXEL_W-1:0] mem_wdata,
  output logic               job_valid,
  output job_t               job,
  output logic [CNT_W-1:0]   job_count,
  input  logic               job_take
);

  logic [SCALE_REG_W-1:0] scale;
  logic [WIDTH_REG_W-1:0] source_width;
  logic [COL_W-1:0]       column;
  logic [CNT_W-1:0]       replays_left;

  logic [CNT_W-1:0] scale_eff;
  logic [WW-1:0]    width_eff;
  logic             accept;
  logic             is_replay;
  logic             reject;
  logic             row_end;
  logic [1:0]       pad;
  logic [1:0]       w2;
  logic [1:0]       s2;

  always_comb begin
    if (scale == '0) begin
      scale_eff = CNT_W'(1);
    end else if (int'(scale) > MAX_SCALE) begin
      scale_eff = CNT_W'(MAX_SCALE);
    end else begin
      scale_eff = CNT_W'(scale);
    end
    if (source_width == '0) begin
      width_eff = WW'(1);
    end else if (int'(source_width) > MAX_WIDTH) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(source_width);
    end
  end

  assign w2 = 2'(width_eff);
  assign s2 = 2'(scale_eff);
  assign pad = 2'(w2 * s2);
  assign row_end = (int'(column) + 1) >= int'(width_eff);

  assign cmd_stall = job_valid & ~job_take;
  assign accept = cmd_valid & ~cmd_stall;
  assign is_replay = (cmd.command == CMD_REPLAY);
  assign reject = is_replay != (replays_left != '0);

  assign mem_we = accept & ~reject & ~is_replay;
  assign mem_re = accept & ~reject & is_replay;
  assign mem_addr = column;
  assign mem_wdata = {cmd.red, cmd.green, cmd.blue};

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_REG_W'(1);
      source_width <= WIDTH_REG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE:        scale <= SCALE_REG_W'(cfg_data);
        REG_SOURCE_WIDTH: source_width <= WIDTH_REG_W'(cfg_data);
        default:          scale <= scale;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      replays_left <= '0;
      job_valid <= 1'b0;
    end else begin
      if (accept && !reject) begin
        if (row_end) begin
          column <= '0;
          replays_left <= is_replay ? replays_left - CNT_W'(1) : scale_eff - CNT_W'(1);
        end else begin
          column <= column + COL_W'(1);
        end
      end
      if (accept) begin
        job_valid <= 1'b1;
      end else if (job_take) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job.reject <= reject;
      job.use_mem <= is_replay & ~reject;
      job.row_end <= row_end & ~reject;
      job.pad <= pad;
      job.pixel <= reject ? '0 : mem_wdata;
      job_count <= reject ? CNT_W'(1) : scale_eff;
    end
  end

endmodule

### rtl/pru_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_emitter
// Output register that repeats one job's pixel once per cycle while pix_stall
// is low, until its copy count is spent.
// ----------------------------------------------------------------------------
module pru_emitter
  import pru_pkg::*;
#(
  parameter int MAX_SCALE = 16,
  localparam int CNT_W = $clog2(MAX_SCALE + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  job_t               job,
  input  logic [CNT_W-1:0]   job_count,
  input  logic [PIXEL_W-1:0] mem_rdata,
  output logic               job_take,
  output logic               pix_valid,
  input  logic               pix_stall,
  output pix_req_t           pix
);

  logic [CNT_W-1:0]   count;
  logic [PIXEL_W-1:0] pixel;
  logic               row_end;
  logic [1:0]         pad;
  logic               reject;
  logic               fire;
  logic               final_copy;

  assign final_copy = (count == CNT_W'(1));
  assign fire = pix_valid & ~pix_stall;
  assign job_take = job_valid & (~pix_valid | (fire & final_copy));

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (job_take) begin
      pix_valid <= 1'b1;
    end else if (fire && final_copy) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      count <= job_count;
      pixel <= job.use_mem ? mem_rdata : job.pixel;
      row_end <= job.row_end;
      pad <= job.pad;
      reject <= job.reject;
    end else if (fire) begin
      count <= count - CNT_W'(1);
    end
  end

  always_comb begin
    pix.out_blue = pixel[7:0];
    pix.out_green = pixel[15:8];
    pix.out_red = pixel[23:16];
    pix.last = final_copy;
    pix.row_end = final_copy & row_end;
    pix.pad_bytes = (final_copy && row_end) ? pad : 2'b00;
    pix.status = reject ? ST_REJECT : ST_PIXEL;
  end

endmodule

### rtl/pixel_replicate_upscaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_replicate_upscaler
// Integer nearest-neighbor upscaler for 24-bit pixel rows.
// ----------------------------------------------------------------------------
// The cmd channel takes push requests carrying a source pixel and replay
// requests that re-read the next stored pixel of the row from the line store.
// Each accepted request produces scale output requests on the pix channel,
// one per cycle unless pix_stall holds the output; a request in the wrong
// phase produces a single rejected result. The final copy of each output row
// carries row_end and pad_bytes. The user must write scale and source_width
// on the cfg port only while the block is idle; the block does not enforce it.
// The output register sets throughput: one output per cycle while pix_stall
// is low; the next job moves in as the last copy of the one before leaves,
// so consecutive requests stream without gaps at the output. A one-entry
// job register sits between the request port and the output register, so
// one request is taken while the output is stalled. Reset sets scale and
// source_width to one and clears the valid flags, the row position and the
// phase; the line store is not cleared. When pix_stall is high the output
// holds its value and, once the job register is full, cmd_stall rises.
// ----------------------------------------------------------------------------
module pixel_replicate_upscaler
  import pru_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_req_t              cmd,
  output logic                  pix_valid,
  input  logic                  pix_stall,
  output pix_req_t              pix
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CNT_W = $clog2(MAX_SCALE + 1);

  logic               mem_we;
  logic               mem_re;
  logic [COL_W-1:0]   mem_addr;
  logic [PIXEL_W-1:0] mem_wdata;
  logic [PIXEL_W-1:0] mem_rdata;
  logic               job_valid;
  job_t               job;
  logic [CNT_W-1:0]   job_count;
  logic               job_take;

  pru_ctrl #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_SCALE(MAX_SCALE)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .mem_we(mem_we),
    .mem_re(mem_re),
    .mem_addr(mem_addr),
    .mem_wdata(mem_wdata),
    .job_valid(job_valid),
    .job(job),
    .job_count(job_count),
    .job_take(job_take)
  );

  pru_line_store #(
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk(clk),
    .we(mem_we),
    .re(mem_re),
    .addr(mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  pru_emitter #(
    .MAX_SCALE(MAX_SCALE)
  ) u_emitter (
    .clk(clk),
    .rst(rst),
    .job_valid(job_valid),
    .job(job),
    .job_count(job_count),
    .mem_rdata(mem_rdata),
    .job_take(job_take),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix(pix)
  );

endmodule

### rtl/pru_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pru_checker
// Port-level checks on the output channel of the upscaler.
// ----------------------------------------------------------------------------
module pru_checker
  import pru_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     pix_valid,
  input logic     pix_stall,
  input pix_req_t pix
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |=> pix_valid && $stable(pix))
    else $error("Stalled output request changed.");

  a_reject_single: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix.status == ST_REJECT |-> pix.last && !pix.row_end)
    else $error("Rejected result is not a lone final result.");

  a_row_end_last: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix.row_end |-> pix.last)
    else $error("Row end on a copy that is not the final one.");

  a_pad_at_row_end: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix.row_end |-> pix.pad_bytes == 2'b00)
    else $error("Padding reported away from a row end.");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !pix_valid)
    else $error("Output valid right after reset.");

endmodule

bind pixel_replicate_upscaler pru_checker u_pru_checker (
  .clk(clk),
  .rst(rst),
  .pix_valid(pix_valid),
  .pix_stall(pix_stall),
  .pix(pix)
);

### dv/pixel_replicate_upscaler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_replicate_upscaler_tb
// Self-checking testbench for the pixel replicate upscaler.
// ----------------------------------------------------------------------------
// A short table of directed requests covers reset behavior, rejected requests,
// the scale and width limits and every padding count. Random rows follow,
// mostly well-formed push and replay sequences with some wrong-phase requests
// mixed in. Each pixel result is checked against its table row's expected
// result or a local model of the line store, row position and replay phase.
// Both channels idle at random, and one long output hold fills the block up.
// ----------------------------------------------------------------------------
module pixel_replicate_upscaler_tb;
  import pru_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_S = 16;
  localparam int RANDOM_ITEMS = 200;
  localparam int HOLD_CYCLES = 80;
  localparam pix_req_t REJECTED = '{8'h00, 8'h00, 8'h00, 2'd0, 1'b0, 1'b1, ST_REJECT};

  typedef struct packed {
    logic                  is_cfg;
    cfg_index_t            reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    cmd_req_t              req;
    logic                  typed;
    pix_req_t              want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  cfg_index_t            cfg_index = REG_SCALE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_stall;
  cmd_req_t              cmd = '0;
  logic                  pix_valid;
  logic                  pix_stall = 1'b0;
  pix_req_t              pix;

  logic [PIXEL_W-1:0]    px_store [MAX_W];
  int unsigned           row_col;
  int unsigned           rows_to_replay;
  logic [4:0]            scale_reg;
  logic [10:0]           width_reg;

  pix_req_t              pending_pix [$];
  pix_req_t              step_out [$];
  pix_req_t              head_pix;
  stim_row_t             stim_rows [$];
  int unsigned           mismatches;
  bit                    idle_on;
  int unsigned           hold_asks;
  int unsigned           holds_done;
  int unsigned           hold_left;

  pixel_replicate_upscaler #(
    .MAX_WIDTH(MAX_W),
    .MAX_SCALE(MAX_S)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix(pix)
  );

  always #2 clk = ~clk;

  function automatic void predict_copies(cmd_req_t req);
    int unsigned s;
    int unsigned w;
    int unsigned col;
    int unsigned k;
    logic [PIXEL_W-1:0] px;
    bit rend;
    bit fin;
    pix_req_t r;
    s = (scale_reg == 0) ? 1 : ((scale_reg > MAX_S) ? MAX_S : scale_reg);
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
    col = row_col % MAX_W;
    step_out.delete();
    if ((req.command == CMD_REPLAY) != (rows_to_replay != 0)) begin
      step_out.push_back(REJECTED);
      return;
    end
    if (req.command == CMD_PUSH) begin
      px = {req.red, req.green, req.blue};
      px_store[col] = px;
    end else begin
      px = px_store[col];
    end
    rend = (col + 1 >= w);
    for (k = 0; k < s; k++) begin
      fin = (k + 1 == s);
      r.out_blue = px[7:0];
      r.out_green = px[15:8];
      r.out_red = px[23:16];
      r.row_end = fin && rend;
      r.pad_bytes = (fin && rend) ? 2'((w * s) % 4) : 2'd0;
      r.last = fin;
      r.status = ST_PIXEL;
      step_out.push_back(r);
    end
    if (rend) begin
      row_col = 0;
      if (req.command == CMD_PUSH) begin
        rows_to_replay = s - 1;
      end else begin
        rows_to_replay = rows_to_replay - 1;
      end
    end else begin
      row_col = col + 1;
    end
  endfunction

  function automatic stim_row_t cfg_row(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_data = data;
    return row;
  endfunction

  function automatic stim_row_t cmd_row(logic c, logic [23:0] bgr, logic typed = 1'b0,
                                        pix_req_t want = '0);
    stim_row_t row;
    row = '0;
    row.req = {c, bgr};
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  task automatic send_request(cmd_req_t req, logic typed, pix_req_t want);
    if (idle_on && $urandom_range(99) < 36) begin
      cmd_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 36);
    end
    cmd_valid <= 1'b1;
    cmd <= req;
    do @(posedge clk); while (cmd_stall);
    predict_copies(req);
    if (typed) begin
      pending_pix.push_back(want);
    end else begin
      foreach (step_out[i]) pending_pix.push_back(step_out[i]);
    end
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == REG_SCALE) begin
      scale_reg = data[4:0];
    end else begin
      width_reg = data;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    do @(negedge clk); while (pending_pix.size() != 0);
  endtask

  always @(negedge clk) begin
    if (holds_done != hold_asks) begin
      holds_done = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      pix_stall <= 1'b1;
    end else begin
      pix_stall <= idle_on && ($urandom_range(99) < 36);
    end
  end

  always @(posedge clk) begin
    if (!rst && pix_valid && !pix_stall) begin
      if (pending_pix.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected pixel result: b=%h g=%h r=%h pad=%0d row_end=%b last=%b st=%b",
                   pix.out_blue, pix.out_green, pix.out_red, pix.pad_bytes, pix.row_end,
                   pix.last, pix.status);
        end
      end else begin
        head_pix = pending_pix.pop_front();
        if (pix.out_blue !== head_pix.out_blue || pix.out_green !== head_pix.out_green ||
            pix.out_red !== head_pix.out_red || pix.pad_bytes !== head_pix.pad_bytes ||
            pix.row_end !== head_pix.row_end || pix.last !== head_pix.last ||
            pix.status !== head_pix.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Pixel mismatch: expected b=%h g=%h r=%h pad=%0d row_end=%b last=%b st=%b",
                     head_pix.out_blue, head_pix.out_green, head_pix.out_red,
                     head_pix.pad_bytes, head_pix.row_end, head_pix.last, head_pix.status);
            $display("                got      b=%h g=%h r=%h pad=%0d row_end=%b last=%b st=%b",
                     pix.out_blue, pix.out_green, pix.out_red, pix.pad_bytes, pix.row_end,
                     pix.last, pix.status);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("pixel_replicate_upscaler_tb failed");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned n;
    int unsigned i;
    logic [CFG_DATA_W-1:0] data;
    cmd_req_t req;

    row_col = 0;
    rows_to_replay = 0;
    scale_reg = 5'd1;
    width_reg = 11'd1;
    mismatches = 0;
    idle_on = 1'b1;
    hold_asks = 0;
    holds_done = 0;
    hold_left = 0;

    stim_rows.push_back(cmd_row(CMD_REPLAY, 24'hFFFFFF, 1'b1, REJECTED));
    stim_rows.push_back(cmd_row(CMD_PUSH, 24'h000000, 1'b1,
                                '{8'h00, 8'h00, 8'h00, 2'd1, 1'b1, 1'b1, ST_PIXEL}));
    stim_rows.push_back(cmd_row(CMD_PUSH, 24'hFFFFFF, 1'b1,
                                '{8'hFF, 8'hFF, 8'hFF, 2'd1, 1'b1, 1'b1, ST_PIXEL}));
    stim_rows.push_back(cfg_row(REG_SCALE, 11'd0));
    stim_rows.push_back(cmd_row(CMD_PUSH, 24'h5AA53C, 1'b1,
                                '{8'h5A, 8'hA5, 8'h3C, 2'd1, 1'b1, 1'b1, ST_PIXEL}));
    stim_rows.push_back(cfg_row(REG_SCALE, 11'd3));
    stim_rows.push_back(cfg_row(REG_SOURCE_WIDTH, 11'd2047));
    stim_rows.push_back(cmd_row(CMD_PUSH, 24'h123456));
    stim_rows.push_back(cmd_row(CMD_PUSH, 24'hA0B0C0));
    stim_rows.push_back(cmd_row(CMD_PUSH, 24'h0F1E2D));
    stim_rows.push_back(cmd_row(CMD_REPLAY, 24'h000000, 1'b1, REJECTED));
    stim_rows.push_back(cfg_row(REG_SOURCE_WIDTH, 11'd2));
    stim_rows.push_back(cmd_row(CMD_PUSH, 24'h8899AA));
    stim_rows.push_back(cmd_row(CMD_PUSH, 24'hFFFFFF, 1'b1, REJECTED));
    for (i = 0; i < 4; i++) begin
      stim_rows.push_back(cmd_row(CMD_REPLAY, 24'h55AA55));
    end
    stim_rows.push_back(cfg_row(REG_SOURCE_WIDTH, 11'd3));
    stim_rows.push_back(cfg_row(REG_SCALE, 11'd1));
    stim_rows.push_back(cmd_row(CMD_PUSH, 24'h010203));
    stim_rows.push_back(cmd_row(CMD_PUSH, 24'hFEFDFC));
    stim_rows.push_back(cmd_row(CMD_PUSH, 24'h7F807F));
    stim_rows.push_back(cfg_row(REG_SCALE, 11'd31));
    stim_rows.push_back(cfg_row(REG_SOURCE_WIDTH, 11'd0));
    stim_rows.push_back(cmd_row(CMD_PUSH, 24'hC3D2E1));
    stim_rows.push_back(cmd_row(CMD_REPLAY, 24'h000000));
    stim_rows.push_back(cmd_row(CMD_PUSH, 24'h000000, 1'b1, REJECTED));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (stim_rows[k]) begin
      if (stim_rows[k].is_cfg) begin
        drain();
        write_reg(stim_rows[k].reg_idx, stim_rows[k].reg_data);
      end else begin
        send_request(stim_rows[k].req, stim_rows[k].typed, stim_rows[k].want);
      end
    end

    // Width only changes in the push phase, so a replay never reads a column
    // that no push of the current row or an earlier one has written.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      if ($urandom_range(99) < 60) begin
        n = $urandom_range(99);
        if (n < 70) data = 11'($urandom_range(1, 4));
        else if (n < 85) data = 11'($urandom_range(5, MAX_S));
        else if (n < 95) data = 11'($urandom_range(MAX_S + 1, 31));
        else data = 11'd0;
        if ($urandom_range(9) == 0) data[10:5] = 6'($urandom);
        write_reg(REG_SCALE, data);
      end
      if (rows_to_replay == 0 && $urandom_range(99) < 60) begin
        n = $urandom_range(99);
        if (n < 80) data = 11'($urandom_range(1, 6));
        else if (n < 90) data = 11'($urandom_range(7, 40));
        else if (n < 95) data = 11'd0;
        else data = 11'($urandom_range(MAX_W + 1, 2047));
        write_reg(REG_SOURCE_WIDTH, data);
      end
      if (phase == 4) hold_asks++;
      n = $urandom_range(4, 30);
      for (i = 0; i < n && sent < RANDOM_ITEMS; i++) begin
        idle_on = !(sent >= 90 && sent < 140);
        req.command = (rows_to_replay != 0) ? CMD_REPLAY : CMD_PUSH;
        if ($urandom_range(99) < 8) req.command = ~req.command;
        req.blue = 8'($urandom);
        req.green = 8'($urandom);
        req.red = 8'($urandom);
        send_request(req, 1'b0, '0);
        sent++;
      end
      phase++;
    end
    idle_on = 1'b1;

    drain();
    repeat (20) @(negedge clk);
    mismatches += pending_pix.size();
    if (mismatches == 0) begin
      $display("pixel_replicate_upscaler_tb passed");
    end else begin
      $display("pixel_replicate_upscaler_tb failed");
    end
    $finish;
  end

endmodule
